### rtl/csv_pkg.sv
package csv_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int ERR_WIDTH    = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_TILDE = 8'h7E;

  typedef enum logic [2:0] {
    ST_FIELD  = 3'd0,
    ST_PLAIN  = 3'd1,
    ST_QUOTED = 3'd2,
    ST_QMARK  = 3'd3,
    ST_CR     = 3'd4,
    ST_ERROR  = 3'd5
  } parse_state_t;

  typedef struct packed {
    logic is_nul;
    logic is_lf;
    logic is_cr;
    logic is_quote;
    logic is_comma;
    logic is_plain;
  } byte_class_t;

  typedef struct packed {
    logic                 invalid;
    logic                 doc_end;
    logic [ERR_WIDTH-1:0] error_offset;
  } verdict_t;

endpackage

### rtl/csv_byte_class.sv
module csv_byte_class (
  input  logic [7:0]                data_byte,
  output csv_pkg::byte_class_t      cls
);

  always_comb begin
    cls.is_nul   = (data_byte == csv_pkg::CH_NUL);
    cls.is_lf    = (data_byte == csv_pkg::CH_LF);
    cls.is_cr    = (data_byte == csv_pkg::CH_CR);
    cls.is_quote = (data_byte == csv_pkg::CH_QUOTE);
    cls.is_comma = (data_byte == csv_pkg::CH_COMMA);
    cls.is_plain = (data_byte >= csv_pkg::CH_SPACE) && (data_byte <= csv_pkg::CH_TILDE) &&
                   (data_byte != csv_pkg::CH_QUOTE) && (data_byte != csv_pkg::CH_COMMA);
  end

endmodule

### rtl/csv_parser.sv
module csv_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  csv_pkg::byte_class_t  cls,
  output csv_pkg::verdict_t     verdict
);

  localparam logic [csv_pkg::OFFSET_WIDTH-1:0] OFFSET_MAX = '1;

  csv_pkg::parse_state_t state, state_next;
  logic [csv_pkg::OFFSET_WIDTH-1:0] byte_offset, byte_offset_next;
  logic [csv_pkg::OFFSET_WIDTH-1:0] first_error, first_error_next;
  logic [csv_pkg::OFFSET_WIDTH-1:0] err_sel;
  logic bad;

  always_comb begin
    state_next = csv_pkg::ST_ERROR;
    unique case (state)
      csv_pkg::ST_FIELD: begin
        if (cls.is_quote)      state_next = csv_pkg::ST_QUOTED;
        else if (cls.is_comma) state_next = csv_pkg::ST_FIELD;
        else if (cls.is_cr)    state_next = csv_pkg::ST_CR;
        else if (cls.is_nul)   state_next = csv_pkg::ST_FIELD;
        else if (cls.is_plain) state_next = csv_pkg::ST_PLAIN;
      end
      csv_pkg::ST_PLAIN: begin
        if (cls.is_comma || cls.is_nul) state_next = csv_pkg::ST_FIELD;
        else if (cls.is_cr)             state_next = csv_pkg::ST_CR;
        else if (cls.is_plain)          state_next = csv_pkg::ST_PLAIN;
      end
      csv_pkg::ST_QUOTED: begin
        if (cls.is_quote) state_next = csv_pkg::ST_QMARK;
        else if (cls.is_plain || cls.is_comma || cls.is_cr || cls.is_lf)
          state_next = csv_pkg::ST_QUOTED;
      end
      csv_pkg::ST_QMARK: begin
        if (cls.is_quote)               state_next = csv_pkg::ST_QUOTED;
        else if (cls.is_comma || cls.is_nul) state_next = csv_pkg::ST_FIELD;
        else if (cls.is_cr)             state_next = csv_pkg::ST_CR;
      end
      csv_pkg::ST_CR: begin
        if (cls.is_lf) state_next = csv_pkg::ST_FIELD;
      end
      default: state_next = csv_pkg::ST_ERROR;
    endcase
  end

  always_comb begin
    bad = (state_next == csv_pkg::ST_ERROR);
    // latch on the first transition into error
    if (state != csv_pkg::ST_ERROR && bad) err_sel = byte_offset;
    else                                   err_sel = first_error;

    verdict.invalid = bad;
    verdict.doc_end = cls.is_nul;
    if (csv_pkg::OFFSET_WIDTH >= csv_pkg::ERR_WIDTH)
      verdict.error_offset = bad ? err_sel[csv_pkg::ERR_WIDTH-1:0] : '0;
    else
      verdict.error_offset = bad ? csv_pkg::ERR_WIDTH'(err_sel) : '0;

    if (cls.is_nul) begin
      byte_offset_next = '0;
      first_error_next = '0;
    end else begin
      byte_offset_next = (byte_offset != OFFSET_MAX) ? byte_offset + 1'b1 : byte_offset;
      first_error_next = err_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= csv_pkg::ST_FIELD;
      byte_offset <= '0;
      first_error <= '0;
    end else if (step) begin
      state       <= cls.is_nul ? csv_pkg::ST_FIELD : state_next;
      byte_offset <= byte_offset_next;
      first_error <= first_error_next;
    end
  end

endmodule

### rtl/csv_stream_validator.sv
// channel   dir  tdata fields (low bit up)              tlast
// s_axis    in   data_byte[7:0]                         -
// m_axis    out  invalid, error_offset[31:0], 7'b0 pad  doc_end
//
// One byte per cycle while m_axis is not stalled; each word passes an input
// register and the parser, then lands in the output register.
// The parse state feeds back through csv_parser into the state register.
// Reset (rst, synchronous) clears parser state, offsets and both valids.
// A stalled m_axis holds the result; one more byte waits in the input register.
module csv_stream_validator (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [0] invalid, [32:1] error_offset, [39:33] zero
  output logic        m_axis_tlast    // doc_end
);

  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 advance;
  csv_pkg::byte_class_t cls;
  csv_pkg::verdict_t    verdict;
  csv_pkg::verdict_t    out_reg;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
    end
  end

  csv_byte_class u_class (
    .data_byte (in_byte),
    .cls       (cls)
  );

  csv_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (in_valid && advance),
    .cls     (cls),
    .verdict (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_reg <= verdict;
    end
  end

  assign m_axis_tdata = {7'd0, out_reg.error_offset, out_reg.invalid};
  assign m_axis_tlast = out_reg.doc_end;

endmodule

### rtl/csv_checker.sv
module csv_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_offset_zero_when_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[32:1] == 32'd0)
    else $error("error_offset nonzero on a valid verdict");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[39:33] == 7'd0)
    else $error("tdata pad bits nonzero");

  a_ready_follows_sink: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

  a_nul_ends_doc: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tdata == 8'h00 ##1 m_axis_tready
    |=> m_axis_tvalid && m_axis_tlast)
    else $error("NUL word did not end the document");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

endmodule

bind csv_stream_validator csv_checker u_csv_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/csv_stream_validator_test.sv
`timescale 1ns / 100ps

module csv_stream_validator_test;

  localparam int QUIET_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 12;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  csv_stream_validator u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  // parser shadow
  csv_pkg::parse_state_t            csv_state = csv_pkg::ST_FIELD;
  logic [csv_pkg::OFFSET_WIDTH-1:0] byte_pos  = '0;
  logic [csv_pkg::OFFSET_WIDTH-1:0] err_pos   = '0;

  csv_pkg::verdict_t pending_verdicts[$];
  logic [7:0] doc_bytes[$];
  int         src_idle  = 0;
  int         sink_idle = 0;
  int         sent      = 0;
  int         mismatches = 0;
  int         quiet     = 0;

  function automatic logic plain_char(input logic [7:0] c);
    return c >= csv_pkg::CH_SPACE && c <= csv_pkg::CH_TILDE &&
           c != csv_pkg::CH_QUOTE && c != csv_pkg::CH_COMMA;
  endfunction

  function automatic csv_pkg::verdict_t next_verdict(input logic [7:0] c);
    csv_pkg::parse_state_t nxt;
    logic                  done;
    csv_pkg::verdict_t     v;
    nxt  = csv_pkg::ST_ERROR;
    done = (c == csv_pkg::CH_NUL);
    case (csv_state)
      csv_pkg::ST_FIELD: begin
        if (c == csv_pkg::CH_QUOTE) nxt = csv_pkg::ST_QUOTED;
        else if (c == csv_pkg::CH_COMMA) nxt = csv_pkg::ST_FIELD;
        else if (c == csv_pkg::CH_CR) nxt = csv_pkg::ST_CR;
        else if (done) nxt = csv_pkg::ST_FIELD;
        else if (plain_char(c)) nxt = csv_pkg::ST_PLAIN;
      end
      csv_pkg::ST_PLAIN: begin
        if (c == csv_pkg::CH_COMMA || done) nxt = csv_pkg::ST_FIELD;
        else if (c == csv_pkg::CH_CR) nxt = csv_pkg::ST_CR;
        else if (plain_char(c)) nxt = csv_pkg::ST_PLAIN;
      end
      csv_pkg::ST_QUOTED: begin
        if (c == csv_pkg::CH_QUOTE) nxt = csv_pkg::ST_QMARK;
        else if (plain_char(c) || c == csv_pkg::CH_COMMA || c == csv_pkg::CH_CR ||
                 c == csv_pkg::CH_LF) nxt = csv_pkg::ST_QUOTED;
      end
      csv_pkg::ST_QMARK: begin
        if (c == csv_pkg::CH_QUOTE) nxt = csv_pkg::ST_QUOTED;
        else if (c == csv_pkg::CH_COMMA || done) nxt = csv_pkg::ST_FIELD;
        else if (c == csv_pkg::CH_CR) nxt = csv_pkg::ST_CR;
      end
      csv_pkg::ST_CR: begin
        if (c == csv_pkg::CH_LF) nxt = csv_pkg::ST_FIELD;
      end
      default: nxt = csv_pkg::ST_ERROR;
    endcase
    if (csv_state != csv_pkg::ST_ERROR && nxt == csv_pkg::ST_ERROR) err_pos = byte_pos;
    csv_state      = nxt;
    v.invalid      = (nxt == csv_pkg::ST_ERROR);
    v.doc_end      = done;
    v.error_offset = v.invalid ? csv_pkg::ERR_WIDTH'(err_pos) : '0;
    if (done) begin
      csv_state = csv_pkg::ST_FIELD;
      byte_pos  = '0;
      err_pos   = '0;
    end else if (byte_pos != '1) begin
      byte_pos++;
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch %s got %0h want %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(negedge clk) begin
    m_axis_tready <= !rst && ($urandom_range(99) >= sink_idle);
  end

  // result check
  always @(posedge clk) begin
    csv_pkg::verdict_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_verdicts.size() == 0) begin
        report_mismatch("unexpected word", 64'(m_axis_tdata), 64'(0));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[0] !== want.invalid)
          report_mismatch("invalid", 64'(m_axis_tdata[0]), 64'(want.invalid));
        if (m_axis_tdata[csv_pkg::ERR_WIDTH:1] !== want.error_offset)
          report_mismatch("error_offset", 64'(m_axis_tdata[csv_pkg::ERR_WIDTH:1]),
                          64'(want.error_offset));
        if (m_axis_tlast !== want.doc_end)
          report_mismatch("doc_end", 64'(m_axis_tlast), 64'(want.doc_end));
        if (m_axis_tdata[39:csv_pkg::ERR_WIDTH+1] !== '0)
          report_mismatch("pad", 64'(m_axis_tdata[39:csv_pkg::ERR_WIDTH+1]), 64'(0));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    pending_verdicts.push_back(next_verdict(b));
    sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_byte(s[i]);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid = 1'b0;
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  function automatic logic [7:0] rand_plain();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (!plain_char(c));
    return c;
  endfunction

  task automatic build_doc();
    int kind, records, fields, len;
    doc_bytes.delete();
    kind = $urandom_range(99);
    if (kind < 15) begin
      len = $urandom_range(1, 12);
      repeat (len) doc_bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      records = $urandom_range(0, 3);
      for (int r = 0; r < records; r++) begin
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
          if (f > 0) doc_bytes.push_back(csv_pkg::CH_COMMA);
          case ($urandom_range(2))
            1: repeat ($urandom_range(1, 6)) doc_bytes.push_back(rand_plain());
            2: begin
              doc_bytes.push_back(csv_pkg::CH_QUOTE);
              repeat ($urandom_range(0, 6)) begin
                case ($urandom_range(9))
                  0: begin
                    doc_bytes.push_back(csv_pkg::CH_QUOTE);
                    doc_bytes.push_back(csv_pkg::CH_QUOTE);
                  end
                  1: doc_bytes.push_back(csv_pkg::CH_COMMA);
                  2: doc_bytes.push_back(csv_pkg::CH_CR);
                  3: doc_bytes.push_back(csv_pkg::CH_LF);
                  default: doc_bytes.push_back(rand_plain());
                endcase
              end
              doc_bytes.push_back(csv_pkg::CH_QUOTE);
            end
            default: ;
          endcase
        end
        if (r < records - 1 || $urandom_range(1)) begin
          doc_bytes.push_back(csv_pkg::CH_CR);
          doc_bytes.push_back(csv_pkg::CH_LF);
        end
      end
      // corrupt one byte now and then
      if (kind < 35 && doc_bytes.size() > 0)
        doc_bytes[$urandom_range(doc_bytes.size() - 1)] = 8'($urandom_range(0, 255));
    end
    doc_bytes.push_back(csv_pkg::CH_NUL);
  endtask

  task automatic test_well_formed();
    send_byte(csv_pkg::CH_NUL);
    send_text("\"x\"\",\r\n\"");
    send_byte(csv_pkg::CH_NUL);
    send_text("~,\r\n\r\n, ");
    send_byte(csv_pkg::CH_NUL);
  endtask

  task automatic test_malformed();
    send_text("a\rb");
    send_byte(8'hFF);
    send_byte(csv_pkg::CH_NUL);
    send_text("\"");
    send_byte(csv_pkg::CH_NUL);
    send_byte(csv_pkg::CH_CR);
    send_byte(csv_pkg::CH_NUL);
    send_byte(8'h7F);
    send_byte(csv_pkg::CH_NUL);
  endtask

  task automatic test_random_docs(input int src_pct, input int sink_pct, input int n_bytes);
    int target;
    src_idle  = src_pct;
    sink_idle = sink_pct;
    target    = sent + n_bytes;
    while (sent < target) begin
      build_doc();
      foreach (doc_bytes[i]) send_byte(doc_bytes[i]);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    src_idle  = 23;
    sink_idle = 59;
    test_well_formed();
    test_malformed();
    hold_until_drained();
    test_random_docs(23, 59, 300);
    test_random_docs(59, 23, 300);
    test_random_docs(0, 0, 300);
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
